>>> hdl/udpsd_pkg.sv
// ----------------------------------------------------------------------------
// udpsd_pkg
// Shared types and constants of the UDP socket demultiplexer table.
// ----------------------------------------------------------------------------
package udpsd_pkg;

  localparam int SOCK_CNT = 8;
  localparam int SOCK_W   = (SOCK_CNT > 1) ? $clog2(SOCK_CNT) : 1;
  localparam int SNUM_W   = 4;
  localparam int OWNER_W  = 3;

  localparam logic [SNUM_W-1:0] NO_SOCKET    = SNUM_W'(SOCK_CNT);
  localparam logic [31:0]       ALL_ONES_IP  = 32'hffff_ffff;
  localparam logic [47:0]       ALL_ONES_MAC = 48'hffff_ffff_ffff;
  localparam logic [15:0]       HEADER_BYTES = 16'd8;

  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_CLOSE   = 2'd1,
    MODE_RX      = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_NO_MATCH  = 3'd2,
    ST_BAD_CSUM  = 3'd3,
    ST_BUSY      = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  typedef enum logic [0:0] {
    CFG_OWN_IP      = 1'b0,
    CFG_SUBNET_MASK = 1'b1
  } cfg_reg_t;

  // Result of comparing one table entry against the held request.
  typedef struct packed {
    logic free;
    logic match;
  } cmp_res_t;

endpackage

>>> hdl/udpsd_cmp.sv
// ----------------------------------------------------------------------------
// udpsd_cmp
// Shared entry compare unit: free test and header match for one entry.
// ----------------------------------------------------------------------------
module udpsd_cmp (
  input  logic [15:0]         entry_port,
  input  logic [31:0]         entry_peer_ip,
  input  logic [15:0]         hdr_port,
  input  logic [31:0]         remote_ip,
  input  logic [31:0]         own_ip,
  input  logic [31:0]         subnet_mask,
  output udpsd_pkg::cmp_res_t res
);

  logic [31:0] bcast;
  logic        peer_ok;

  always_comb begin
    bcast   = own_ip | ~subnet_mask;
    peer_ok = (entry_peer_ip == remote_ip) || (entry_peer_ip == bcast) ||
              (entry_peer_ip == udpsd_pkg::ALL_ONES_IP);
    res.free  = (entry_port == 16'd0);
    // a zero port is free and never matches
    res.match = (entry_port != 16'd0) && (entry_port == hdr_port) && peer_ok;
  end

endmodule

>>> hdl/udp_socket_demux_table.sv
// ----------------------------------------------------------------------------
// udp_socket_demux_table
// UDP socket table: open, close, header demultiplexing and one pending packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   open, close, received header or release, selected by in_mode.
//   Result channel (out_valid / out_stall) returns exactly one result per
//   request: status, socket number and the pending-packet view afterwards.
//   Config port (cfg_valid / cfg_ready, cfg_index, cfg_data) writes own_ip
//   (index 0) and subnet_mask (index 1); cfg_ready is high whenever reset is
//   released. Write it only while no request is in flight.
// Timing:
//   Open and received header walk the table one entry per cycle through a
//   single compare unit, visiting 1 to 8 entries; close, release and a
//   header while busy skip the walk.
//   in_stall is high during reset and from the accepted transfer until the
//   result is loaded into the output register; the next request may enter
//   while that result still waits.
// Reset (rst_n low, synchronous): all entries free, nothing pending,
//   own_ip 0, subnet_mask all ones, output empty.
// Stall: a stalled result holds in the output register; the sequencer then
//   waits in its final step, so in_stall stays high until room appears.
// ----------------------------------------------------------------------------
module udp_socket_demux_table (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_socket_index,
  input  logic [15:0] in_local_port,
  input  logic [15:0] in_remote_port,
  input  logic [31:0] in_remote_ip,
  input  logic [47:0] in_remote_mac,
  input  logic        in_any_remote,
  input  logic [31:0] in_dest_ip,
  input  logic [15:0] in_payload_length,
  input  logic        in_checksum_valid,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_socket_number,
  output logic        out_pending_valid,
  output logic [2:0]  out_pending_socket,
  output logic [15:0] out_pending_length,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int N = udpsd_pkg::SOCK_CNT;
  localparam int W = udpsd_pkg::SOCK_W;

  // configuration registers
  logic [31:0] own_ip_r;
  logic [31:0] subnet_mask_r;

  // socket table
  logic [15:0] entry_port_r       [N];
  logic [15:0] entry_reply_port_r [N];
  logic [31:0] entry_peer_ip_r    [N];
  logic [47:0] entry_peer_mac_r   [N];
  logic [31:0] entry_last_dest_r  [N];

  // pending packet
  logic        pend_r,  pend_nxt;
  logic [2:0]  owner_r, owner_nxt;
  logic [15:0] held_r,  held_nxt;

  // held request
  udpsd_pkg::mode_t mode_r;
  logic [3:0]  sidx_r;
  logic [15:0] lport_r;
  logic [15:0] rport_r;
  logic [31:0] rip_r;
  logic [47:0] rmac_r;
  logic        any_r;
  logic [31:0] dip_r;
  logic [15:0] plen_r;
  logic        csum_r;

  // sequencer
  udpsd_pkg::fsm_t state_r, state_nxt;
  logic [W-1:0] idx_r, idx_nxt;
  logic         found_r, found_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_sock_r, out_sock_nxt;

  // table update strobes
  logic        wr_open, wr_rx, wr_learn, wr_close;
  logic        in_xfer, out_room, close_bad;
  logic [W-1:0] sidx_w;

  udpsd_pkg::cmp_res_t cmp_res;

  udpsd_cmp u_cmp (
    .entry_port    (entry_port_r[idx_r]),
    .entry_peer_ip (entry_peer_ip_r[idx_r]),
    .hdr_port      (lport_r),
    .remote_ip     (rip_r),
    .own_ip        (own_ip_r),
    .subnet_mask   (subnet_mask_r),
    .res           (cmp_res)
  );

  // hold off requests and writes while reset is applied
  assign in_stall  = !rst_n || (state_r != udpsd_pkg::FSM_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_room  = !out_valid_r || !out_stall;
  assign cfg_ready = rst_n;
  assign sidx_w    = sidx_r[W-1:0];
  assign close_bad = ({28'd0, sidx_r} >= 32'(N));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r      <= 32'd0;
      subnet_mask_r <= udpsd_pkg::ALL_ONES_IP;
    end else if (cfg_valid && cfg_ready) begin
      case (udpsd_pkg::cfg_reg_t'(cfg_index))
        udpsd_pkg::CFG_OWN_IP:      own_ip_r      <= cfg_data;
        udpsd_pkg::CFG_SUBNET_MASK: subnet_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the request on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= udpsd_pkg::mode_t'(in_mode);
      sidx_r  <= in_socket_index;
      lport_r <= in_local_port;
      rport_r <= in_remote_port;
      rip_r   <= in_remote_ip;
      rmac_r  <= in_remote_mac;
      any_r   <= in_any_remote;
      dip_r   <= in_dest_ip;
      plen_r  <= in_payload_length;
      csum_r  <= in_checksum_valid;
    end
  end

  // sequencer: next state, result and table strobes
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    pend_nxt       = pend_r;
    owner_nxt      = owner_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_sock_nxt   = out_sock_r;
    wr_open        = 1'b0;
    wr_rx          = 1'b0;
    wr_learn       = 1'b0;
    wr_close       = 1'b0;

    case (state_r)
      udpsd_pkg::FSM_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if ((in_mode == udpsd_pkg::MODE_OPEN) ||
              ((in_mode == udpsd_pkg::MODE_RX) && !pend_r)) begin
            state_nxt = udpsd_pkg::FSM_SCAN;
          end else begin
            state_nxt = udpsd_pkg::FSM_DONE;
          end
        end
      end

      udpsd_pkg::FSM_SCAN: begin
        // stop at the lowest hit; otherwise advance until the last entry
        if (((mode_r == udpsd_pkg::MODE_OPEN) && cmp_res.free) ||
            ((mode_r == udpsd_pkg::MODE_RX) && cmp_res.match)) begin
          found_nxt = 1'b1;
          state_nxt = udpsd_pkg::FSM_DONE;
        end else if (idx_r == W'(N - 1)) begin
          state_nxt = udpsd_pkg::FSM_DONE;
        end else begin
          idx_nxt = idx_r + W'(1);
        end
      end

      udpsd_pkg::FSM_DONE: begin
        if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = udpsd_pkg::ST_OK;
          out_sock_nxt   = udpsd_pkg::NO_SOCKET;
          state_nxt      = udpsd_pkg::FSM_IDLE;
          case (mode_r)
            udpsd_pkg::MODE_OPEN: begin
              if (found_r) begin
                wr_open      = 1'b1;
                out_sock_nxt = 4'(idx_r);
              end else begin
                out_status_nxt = udpsd_pkg::ST_NO_FREE;
              end
            end
            udpsd_pkg::MODE_CLOSE: begin
              if (close_bad) begin
                out_status_nxt = udpsd_pkg::ST_BAD_INDEX;
              end else begin
                wr_close     = 1'b1;
                out_sock_nxt = sidx_r;
                if (pend_r && ({1'b0, owner_r} == sidx_r)) begin
                  pend_nxt  = 1'b0;
                  owner_nxt = 3'd0;
                  held_nxt  = 16'd0;
                end
              end
            end
            udpsd_pkg::MODE_RX: begin
              if (pend_r) begin
                out_status_nxt = udpsd_pkg::ST_BUSY;
              end else if (!found_r) begin
                out_status_nxt = udpsd_pkg::ST_NO_MATCH;
              end else if (!csum_r) begin
                out_status_nxt = udpsd_pkg::ST_BAD_CSUM;
              end else begin
                wr_rx        = 1'b1;
                wr_learn     = (entry_peer_ip_r[idx_r] == udpsd_pkg::ALL_ONES_IP);
                pend_nxt     = 1'b1;
                owner_nxt    = 3'(idx_r);
                held_nxt     = (plen_r < udpsd_pkg::HEADER_BYTES) ? 16'd0
                               : plen_r - udpsd_pkg::HEADER_BYTES;
                out_sock_nxt = 4'(idx_r);
              end
            end
            udpsd_pkg::MODE_RELEASE: begin
              if (pend_r) begin
                out_sock_nxt = {1'b0, owner_r};
                pend_nxt     = 1'b0;
                owner_nxt    = 3'd0;
                held_nxt     = 16'd0;
              end
            end
            default: ;
          endcase
        end
      end

      default: state_nxt = udpsd_pkg::FSM_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= udpsd_pkg::FSM_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      owner_r     <= 3'd0;
      held_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
      owner_r     <= owner_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_sock_r   <= out_sock_nxt;
  end

  // entry ports: zero marks a free entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        entry_port_r[i] <= 16'd0;
      end
    end else if (wr_open) begin
      entry_port_r[idx_r] <= lport_r;
    end else if (wr_close) begin
      entry_port_r[sidx_w] <= 16'd0;
    end
  end

  // entry payload, no reset: a free entry is never read
  always_ff @(posedge clk) begin
    if (wr_open) begin
      entry_reply_port_r[idx_r] <= rport_r;
      entry_peer_ip_r[idx_r]    <= any_r ? udpsd_pkg::ALL_ONES_IP  : rip_r;
      entry_peer_mac_r[idx_r]   <= any_r ? udpsd_pkg::ALL_ONES_MAC : rmac_r;
    end else if (wr_rx) begin
      entry_reply_port_r[idx_r] <= rport_r;
      entry_last_dest_r[idx_r]  <= dip_r;
      // a broadcast entry learns its peer from the first packet
      if (wr_learn) begin
        entry_peer_ip_r[idx_r]  <= rip_r;
        entry_peer_mac_r[idx_r] <= rmac_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_socket_number  = out_sock_r;
  assign out_pending_valid  = pend_r;
  assign out_pending_socket = owner_r;
  assign out_pending_length = held_r;

endmodule

>>> tb/tb_udp_socket_demux_table.sv
// ----------------------------------------------------------------------------
// tb_udp_socket_demux_table
// Self-checking bench for the UDP socket table: open, close, header match and
// release are driven over the valid/stall channel, and every result transfer
// is compared field by field with a cycle-free prediction of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_udp_socket_demux_table;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 310;
  localparam int DRAIN_CYCLES = 16;

  // One request as it crosses the input channel.
  typedef struct {
    udpsd_pkg::mode_t mode;
    logic [3:0]  sidx;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [31:0] rip;
    logic [47:0] rmac;
    logic        any;
    logic [31:0] dip;
    logic [15:0] plen;
    logic        csum_ok;
  } sock_req_t;

  // One result as it crosses the output channel.
  typedef struct {
    udpsd_pkg::status_t status;
    logic [3:0]  sock;
    logic        pend_v;
    logic [2:0]  pend_sock;
    logic [15:0] pend_len;
  } demux_outcome_t;

  // --------------------------------------------------------------------------
  // Table prediction and result checking. Only the fields that can reach an
  // output are tracked: local port and peer IP per entry, plus the single
  // pending packet. Reply port, MAC and last destination never show up.
  // --------------------------------------------------------------------------
  class socket_table_checker;
    logic [15:0]    port_tbl [udpsd_pkg::SOCK_CNT];
    logic [31:0]    peer_tbl [udpsd_pkg::SOCK_CNT];
    logic           pend;
    logic [2:0]     owner;
    logic [15:0]    held_len;
    logic [31:0]    own_ip;
    logic [31:0]    subnet_mask;
    demux_outcome_t expected_outcomes [$];
    int             failures;

    function new();
      for (int i = 0; i < udpsd_pkg::SOCK_CNT; i++) begin
        port_tbl[i] = '0;
        peer_tbl[i] = '0;
      end
      pend        = 1'b0;
      owner       = '0;
      held_len    = '0;
      own_ip      = '0;
      subnet_mask = udpsd_pkg::ALL_ONES_IP;
      failures    = 0;
    endfunction

    function void set_reg(udpsd_pkg::cfg_reg_t idx, logic [31:0] val);
      if (idx == udpsd_pkg::CFG_OWN_IP) own_ip = val;
      else subnet_mask = val;
    endfunction

    function int outstanding();
      return expected_outcomes.size();
    endfunction

    function void drop_packet();
      pend     = 1'b0;
      owner    = '0;
      held_len = '0;
    endfunction

    // Advance the table by one accepted request and queue its outcome.
    function void note_request(sock_req_t r);
      demux_outcome_t e;
      int             hit;
      logic [31:0]    bcast;
      e.status = udpsd_pkg::ST_OK;
      e.sock   = udpsd_pkg::NO_SOCKET;
      hit      = -1;
      bcast    = own_ip | ~subnet_mask;
      case (r.mode)
        udpsd_pkg::MODE_OPEN: begin
          for (int i = 0; i < udpsd_pkg::SOCK_CNT; i++)
            if (hit < 0 && port_tbl[i] == 16'd0) hit = i;
          if (hit < 0) begin
            e.status = udpsd_pkg::ST_NO_FREE;
          end else begin
            port_tbl[hit] = r.lport;
            peer_tbl[hit] = r.any ? udpsd_pkg::ALL_ONES_IP : r.rip;
            e.sock        = 4'(hit);
          end
        end
        udpsd_pkg::MODE_CLOSE: begin
          if (r.sidx >= udpsd_pkg::SOCK_CNT) begin
            e.status = udpsd_pkg::ST_BAD_INDEX;
          end else begin
            if (pend && owner == r.sidx[2:0]) drop_packet();
            port_tbl[int'(r.sidx)] = '0;
            e.sock = r.sidx;
          end
        end
        udpsd_pkg::MODE_RX: begin
          if (pend) begin
            e.status = udpsd_pkg::ST_BUSY;
          end else begin
            for (int i = 0; i < udpsd_pkg::SOCK_CNT; i++)
              if (hit < 0 && port_tbl[i] != 16'd0 && port_tbl[i] == r.lport &&
                  (peer_tbl[i] == r.rip || peer_tbl[i] == bcast ||
                   peer_tbl[i] == udpsd_pkg::ALL_ONES_IP))
                hit = i;
            if (hit < 0) begin
              e.status = udpsd_pkg::ST_NO_MATCH;
            end else if (!r.csum_ok) begin
              e.status = udpsd_pkg::ST_BAD_CSUM;
            end else begin
              // a broadcast entry locks onto the first sender it hears
              if (peer_tbl[hit] == udpsd_pkg::ALL_ONES_IP) peer_tbl[hit] = r.rip;
              held_len = (r.plen < udpsd_pkg::HEADER_BYTES) ? 16'd0
                         : r.plen - udpsd_pkg::HEADER_BYTES;
              owner    = 3'(hit);
              pend     = 1'b1;
              e.sock   = 4'(hit);
            end
          end
        end
        default: begin
          if (pend) begin
            e.sock = {1'b0, owner};
            drop_packet();
          end
        end
      endcase
      e.pend_v    = pend;
      e.pend_sock = pend ? owner : 3'd0;
      e.pend_len  = pend ? held_len : 16'd0;
      expected_outcomes.push_back(e);
    endfunction

    function void check_result(demux_outcome_t got);
      demux_outcome_t e;
      if (expected_outcomes.size() == 0) begin
        if (failures < 10)
          $display("ERROR: result transfer with no request waiting (status %0d sock %0d)",
                   got.status, got.sock);
        failures++;
        return;
      end
      e = expected_outcomes.pop_front();
      if (got.status !== e.status || got.sock !== e.sock || got.pend_v !== e.pend_v ||
          got.pend_sock !== e.pend_sock || got.pend_len !== e.pend_len) begin
        if (failures < 10) begin
          $display("ERROR: mismatch exp status %0d sock %0d pend %0b/%0d/%0d",
                   e.status, e.sock, e.pend_v, e.pend_sock, e.pend_len);
          $display("                got status %0d sock %0d pend %0b/%0d/%0d",
                   got.status, got.sock, got.pend_v, got.pend_sock, got.pend_len);
        end
        failures++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [3:0]  in_socket_index = '0;
  logic [15:0] in_local_port = '0;
  logic [15:0] in_remote_port = '0;
  logic [31:0] in_remote_ip = '0;
  logic [47:0] in_remote_mac = '0;
  logic        in_any_remote = 1'b0;
  logic [31:0] in_dest_ip = '0;
  logic [15:0] in_payload_length = '0;
  logic        in_checksum_valid = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_socket_number;
  logic        out_pending_valid;
  logic [2:0]  out_pending_socket;
  logic [15:0] out_pending_length;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  udp_socket_demux_table DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_socket_index    (in_socket_index),
    .in_local_port      (in_local_port),
    .in_remote_port     (in_remote_port),
    .in_remote_ip       (in_remote_ip),
    .in_remote_mac      (in_remote_mac),
    .in_any_remote      (in_any_remote),
    .in_dest_ip         (in_dest_ip),
    .in_payload_length  (in_payload_length),
    .in_checksum_valid  (in_checksum_valid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_socket_number  (out_socket_number),
    .out_pending_valid  (out_pending_valid),
    .out_pending_socket (out_pending_socket),
    .out_pending_length (out_pending_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  socket_table_checker table_chk = new();

  // Percent chance per cycle that the sender holds off / the receiver stalls.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  // Working copy of the registers, used only to aim the stimulus.
  logic [31:0] cur_own_ip = '0;
  logic [31:0] cur_mask = udpsd_pkg::ALL_ONES_IP;
  logic [15:0] port_pool [4];
  logic [31:0] ip_pool [6];
  int          cycle_count = 0;
  demux_outcome_t observed;

  // --------------------------------------------------------------------------
  // Receiver: toss the stall at each falling edge, check each result transfer
  // at the rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      observed.status    = udpsd_pkg::status_t'(out_status);
      observed.sock      = out_socket_number;
      observed.pend_v    = out_pending_valid;
      observed.pend_sock = out_pending_socket;
      observed.pend_len  = out_pending_length;
      table_chk.check_result(observed);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Refresh the port and peer pools so that headers tend to hit open entries.
  // Keep the subnet broadcast and the all-ones address among the peers.
  task automatic refresh_pools();
    for (int i = 0; i < 3; i++) port_pool[i] = 16'($urandom_range(1, 65535));
    port_pool[3] = 16'hffff;
    for (int i = 0; i < 4; i++) ip_pool[i] = $urandom;
    ip_pool[4] = cur_own_ip | ~cur_mask;
    ip_pool[5] = udpsd_pkg::ALL_ONES_IP;
  endtask

  // Fill every field with noise, then set the operation.
  function automatic sock_req_t blank_request(udpsd_pkg::mode_t m);
    sock_req_t r;
    r.mode    = m;
    r.sidx    = 4'($urandom_range(15));
    r.lport   = 16'($urandom);
    r.rport   = 16'($urandom);
    r.rip     = $urandom;
    r.rmac    = {16'($urandom), 32'($urandom)};
    r.any     = 1'($urandom);
    r.dip     = $urandom;
    r.plen    = 16'($urandom);
    r.csum_ok = 1'($urandom);
    return r;
  endfunction

  // Mostly well-formed traffic: opens and headers aimed at the pools,
  // releases to free the pending slot, a sprinkling of noise.
  function automatic sock_req_t rand_request();
    sock_req_t r;
    int        roll;
    int        pick;
    roll = $urandom_range(99);
    if (roll < 20)      r = blank_request(udpsd_pkg::MODE_OPEN);
    else if (roll < 32) r = blank_request(udpsd_pkg::MODE_CLOSE);
    else if (roll < 72) r = blank_request(udpsd_pkg::MODE_RX);
    else                r = blank_request(udpsd_pkg::MODE_RELEASE);

    pick = $urandom_range(99);
    if (pick < 85)      r.lport = port_pool[$urandom_range(3)];
    else if (pick < 92) r.lport = 16'd0;

    if ($urandom_range(99) < 75) r.rip = ip_pool[$urandom_range(5)];
    r.any = ($urandom_range(3) == 0);

    if (r.mode == udpsd_pkg::MODE_CLOSE && $urandom_range(99) < 85)
      r.sidx = 4'($urandom_range(udpsd_pkg::SOCK_CNT - 1));

    if (r.mode == udpsd_pkg::MODE_RX) begin
      pick = $urandom_range(99);
      if (pick < 10)      r.plen = 16'($urandom_range(0, 8));
      else if (pick < 90) r.plen = 16'($urandom_range(8, 1500));
      r.csum_ok = ($urandom_range(99) < 90);
    end
    return r;
  endfunction

  // Present one request and hold it until the transfer happens.
  task automatic send_request(sock_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_mode           <= r.mode;
    in_socket_index   <= r.sidx;
    in_local_port     <= r.lport;
    in_remote_port    <= r.rport;
    in_remote_ip      <= r.rip;
    in_remote_mac     <= r.rmac;
    in_any_remote     <= r.any;
    in_dest_ip        <= r.dip;
    in_payload_length <= r.plen;
    in_checksum_valid <= r.csum_ok;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_chk.note_request(r);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (table_chk.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; only called with the table idle.
  task automatic write_reg(udpsd_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    table_chk.set_reg(idx, val);
    cur_own_ip = (idx == udpsd_pkg::CFG_OWN_IP) ? val : cur_own_ip;
    cur_mask   = (idx == udpsd_pkg::CFG_SUBNET_MASK) ? val : cur_mask;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(int idle_pct, int stall_pct, logic [31:0] ip,
                                  logic [31:0] mask);
    drain_results();
    write_reg(udpsd_pkg::CFG_OWN_IP, ip);
    write_reg(udpsd_pkg::CFG_SUBNET_MASK, mask);
    refresh_pools();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_request(rand_request());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sock_req_t r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: 192.168.1.10/24, broadcast 192.168.1.255.
    write_reg(udpsd_pkg::CFG_OWN_IP, 32'hc0a8_010a);
    write_reg(udpsd_pkg::CFG_SUBNET_MASK, 32'hffff_ff00);
    refresh_pools();

    // release with nothing pending, header to an empty table
    send_request(blank_request(udpsd_pkg::MODE_RELEASE));
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'h1234; r.csum_ok = 1'b0;
    send_request(r);

    // entry 0: fixed peer; entry 1: broadcast peer on the top port
    r = blank_request(udpsd_pkg::MODE_OPEN);
    r.lport = 16'h1234; r.rip = 32'hc0a8_0120; r.any = 1'b0;
    send_request(r);
    r = blank_request(udpsd_pkg::MODE_OPEN);
    r.lport = 16'hffff; r.any = 1'b1;
    send_request(r);
    // port zero open: numbered but stays free, then reused by a subnet-peer open
    r = blank_request(udpsd_pkg::MODE_OPEN);
    r.lport = 16'd0; r.any = 1'b0;
    send_request(r);
    r = blank_request(udpsd_pkg::MODE_OPEN);
    r.lport = 16'h0001; r.rip = 32'hc0a8_01ff; r.any = 1'b0;
    send_request(r);

    // matching header with a bad checksum, wrong sender, then a real match
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'h1234; r.rip = 32'hc0a8_0120; r.csum_ok = 1'b0;
    send_request(r);
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'h1234; r.rip = 32'hc0a8_0121; r.csum_ok = 1'b1;
    send_request(r);
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'h1234; r.rip = 32'hc0a8_0120; r.plen = 16'hffff; r.csum_ok = 1'b1;
    send_request(r);
    // header while a packet is held
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'hffff; r.csum_ok = 1'b1;
    send_request(r);
    send_request(blank_request(udpsd_pkg::MODE_RELEASE));

    // destination port zero never matches
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'd0; r.rip = udpsd_pkg::ALL_ONES_IP; r.csum_ok = 1'b1;
    send_request(r);
    // broadcast entry learns its sender; short length saturates to zero
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'hffff; r.rip = 32'h0a00_0001; r.plen = 16'd3; r.csum_ok = 1'b1;
    send_request(r);
    // close the owner: pending packet goes with it
    r = blank_request(udpsd_pkg::MODE_CLOSE);
    r.sidx = 4'd1;
    send_request(r);
    // out-of-range closes, close of a free entry
    r = blank_request(udpsd_pkg::MODE_CLOSE);
    r.sidx = 4'(udpsd_pkg::SOCK_CNT);
    send_request(r);
    r = blank_request(udpsd_pkg::MODE_CLOSE);
    r.sidx = 4'hf;
    send_request(r);
    r = blank_request(udpsd_pkg::MODE_CLOSE);
    r.sidx = 4'd5;
    send_request(r);
    // subnet-broadcast peer accepts any sender; length of exactly a header
    r = blank_request(udpsd_pkg::MODE_RX);
    r.lport = 16'h0001; r.rip = 32'h0102_0304; r.plen = 16'd8; r.csum_ok = 1'b1;
    send_request(r);
    send_request(blank_request(udpsd_pkg::MODE_RELEASE));

    // fill the table, then one open too many
    for (int k = 0; k < udpsd_pkg::SOCK_CNT - 1; k++) begin
      r = blank_request(udpsd_pkg::MODE_OPEN);
      r.lport = port_pool[k % 4];
      send_request(r);
    end

    // Random part, one register setting per idling profile.
    run_random_phase(12, 74, $urandom, 32'hffff_ff00);
    run_random_phase(74, 12, udpsd_pkg::ALL_ONES_IP, udpsd_pkg::ALL_ONES_IP);
    run_random_phase(0, 0, 32'd0, 32'd0);

    drain_results();
    if (table_chk.failures == 0 && table_chk.outstanding() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
